[src/qbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbc_pkg: shared widths and types for the quintic boundary coefficient block
// Internal word widths, stage counts and the sideband record that travels
// next to the datapath.
// ----------------------------------------------------------------------------
package qbc_pkg;

    // Signed numerator of c3..c5, Q16.16 values against a Q16.16 duration.
    localparam int NUM_W     = 100;
    // Quotient bits produced per divide; one more than the output word so
    // that an overflow of the magnitude can be seen before clamping.
    localparam int Q_BITS    = 65;
    // Entry, setup, one stage per quotient bit, rounding, clamping.
    localparam int DIV_LAT   = Q_BITS + 4;
    localparam int FRONT_LAT = 8;
    localparam int SB_LAT    = FRONT_LAT + DIV_LAT;

    localparam int HT_W = 40;            // h times 20, -30 or 12
    localparam int VT_W = 37;            // velocity combinations
    localparam int AT_W = 35;            // acceleration combinations
    localparam int PV_W = VT_W + 33;     // velocity term times T
    localparam int PA_W = AT_W + 33;     // acceleration term times one T^2 half
    localparam int T3_W = 96;
    localparam int T4_W = 128;
    localparam int T5_W = 160;

    localparam logic [63:0] COEF_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] COEF_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] p0;
        logic signed [31:0] v0;
        logic signed [31:0] a0;
        logic [1:0]         tag;
        logic               zero;
    } t_side;

endpackage
`default_nettype wire

[src/qbc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbc_div: pipelined rounding divider for one coefficient
// Computes round(num * 2^SHIFT / den), half away from zero, clamped to a
// signed 64-bit word, one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module qbc_div #(
    parameter int DEN_W = 97,
    parameter int SHIFT = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic signed [qbc_pkg::NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]                   i_den,
    output logic                                    o_valid,
    output logic [63:0]                             o_coef,
    output logic                                    o_sat
);
    import qbc_pkg::*;

    localparam int XW   = NUM_W + SHIFT;
    localparam int HW   = XW - Q_BITS;
    localparam int CW   = (HW > DEN_W) ? HW : DEN_W;
    localparam int QR_W = Q_BITS + 1;

    logic                 r_a_v;
    logic                 r_a_neg;
    logic [NUM_W-1:0]     r_a_mag;
    logic [DEN_W-1:0]     r_a_den;
    logic [NUM_W-1:0]     n_a_mag;

    logic [XW-1:0]        x_a;
    logic [HW-1:0]        hi_a;
    logic                 n_sat0;

    logic                 r_v   [0:Q_BITS];
    logic                 r_sat [0:Q_BITS];
    logic                 r_neg [0:Q_BITS];
    logic [DEN_W-1:0]     r_rem [0:Q_BITS];
    logic [DEN_W-1:0]     r_den [0:Q_BITS];
    logic [Q_BITS-1:0]    r_low [0:Q_BITS];
    logic [Q_BITS-1:0]    r_q   [0:Q_BITS];

    logic [DEN_W:0]       n_trial [1:Q_BITS];
    logic                 n_bit   [1:Q_BITS];
    logic [DEN_W-1:0]     n_rem   [1:Q_BITS];

    logic                 n_rnd;
    logic                 r_c_v;
    logic                 r_c_neg;
    logic                 r_c_sat;
    logic [QR_W-1:0]      r_c_q;

    logic [QR_W-1:0]      n_neg_q;
    logic [63:0]          n_coef;
    logic                 n_sat;
    logic                 r_o_v;
    logic                 r_o_neg;
    logic [63:0]          r_o_coef;
    logic                 r_o_sat;

    assign n_a_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);

    // The quotient fits in Q_BITS bits exactly when the part of the dividend
    // above those bits is below the divisor.
    assign x_a    = {r_a_mag, {SHIFT{1'b0}}};
    assign hi_a   = x_a[XW-1:Q_BITS];
    assign n_sat0 = CW'(hi_a) >= CW'(r_a_den);

    always_comb begin
        for (int i = 1; i <= Q_BITS; i++) begin
            n_trial[i] = {r_rem[i-1], r_low[i-1][Q_BITS-1]};
            n_bit[i]   = n_trial[i] >= {1'b0, r_den[i-1]};
            n_rem[i]   = n_bit[i] ? DEN_W'(n_trial[i] - {1'b0, r_den[i-1]})
                                  : DEN_W'(n_trial[i]);
        end
    end

    assign n_rnd   = {r_rem[Q_BITS], 1'b0} >= {1'b0, r_den[Q_BITS]};
    assign n_neg_q = QR_W'(0) - r_c_q;

    always_comb begin
        n_coef = r_c_q[63:0];
        n_sat  = 1'b0;
        if (r_c_sat) begin
            n_coef = r_c_neg ? COEF_MIN : COEF_MAX;
            n_sat  = 1'b1;
        end else if (!r_c_neg) begin
            if (r_c_q > QR_W'(COEF_MAX)) begin
                n_coef = COEF_MAX;
                n_sat  = 1'b1;
            end
        end else begin
            if (r_c_q > QR_W'(COEF_MIN)) begin
                n_coef = COEF_MIN;
                n_sat  = 1'b1;
            end else begin
                n_coef = n_neg_q[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            for (int i = 0; i <= Q_BITS; i++) begin
                r_v[i] <= 1'b0;
            end
            r_c_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_a_v   <= i_valid;
            r_v[0]  <= r_a_v;
            for (int i = 1; i <= Q_BITS; i++) begin
                r_v[i] <= r_v[i-1];
            end
            r_c_v <= r_v[Q_BITS];
            r_o_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg  <= i_num[NUM_W-1];
        r_a_mag  <= n_a_mag;
        r_a_den  <= i_den;

        r_sat[0] <= n_sat0;
        r_neg[0] <= r_a_neg;
        r_rem[0] <= DEN_W'(hi_a);
        r_den[0] <= r_a_den;
        r_low[0] <= x_a[Q_BITS-1:0];
        r_q[0]   <= '0;
        for (int i = 1; i <= Q_BITS; i++) begin
            r_sat[i] <= r_sat[i-1];
            r_neg[i] <= r_neg[i-1];
            r_rem[i] <= n_rem[i];
            r_den[i] <= r_den[i-1];
            r_low[i] <= {r_low[i-1][Q_BITS-2:0], 1'b0};
            r_q[i]   <= {r_q[i-1][Q_BITS-2:0], n_bit[i]};
        end

        r_c_neg  <= r_neg[Q_BITS];
        r_c_sat  <= r_sat[Q_BITS];
        r_c_q    <= {1'b0, r_q[Q_BITS]} + QR_W'(n_rnd);

        r_o_neg  <= r_c_neg;
        r_o_coef <= n_coef;
        r_o_sat  <= n_sat;
    end

    assign o_valid = r_o_v;
    assign o_coef  = r_o_coef;
    assign o_sat   = r_o_sat;

    a_rem_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !r_sat[0] |-> r_rem[0] < r_den[0])
        else $error("partial remainder not below divisor after setup");

    a_rem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[Q_BITS] && !r_sat[Q_BITS] |-> r_rem[Q_BITS] < r_den[Q_BITS])
        else $error("partial remainder not below divisor after last bit");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_coef != 64'd0 |-> r_o_coef[63] == r_o_neg)
        else $error("coefficient sign differs from numerator sign");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_v |=> r_o_v)
        else $error("rounded beat lost before the output register");

endmodule
`default_nettype wire

[src/quintic_boundary_coefficients.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quintic_boundary_coefficients: quintic segment coefficients for one axis
// Turns start and end position, velocity, acceleration and a duration T into
// the six Q32.32 coefficients of the quintic that meets them.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is taken at a rising edge where start is high and busy is low.
//   busy is high only while reset is held and until the run flag is registered after it;
//   after that a new beat may be offered in every cycle.
//   Each beat gives one result, shown for one cycle with o_valid high, once
//   it has passed the front stages and the dividers. Results leave in the order of the beats.
//   Throughput is one beat per cycle: eight stages form the T powers and
//   numerators from 32-bit slices of T and its powers, then three dividers run
//   side by side, each a 69-stage pipeline resolving one quotient bit per stage.
//   c0..c2 are exact; c3..c5 are rounded half away from zero and clamped,
//   with o_saturated set on any clamp. A zero duration gives zero c3..c5 and
//   o_saturated high. The axis tag is copied through.
//   Reset empties the pipeline; no result appears from a beat offered during
//   reset. The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module quintic_boundary_coefficients (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_start_position,
    input  wire logic signed [31:0] i_start_velocity,
    input  wire logic signed [31:0] i_start_acceleration,
    input  wire logic signed [31:0] i_end_position,
    input  wire logic signed [31:0] i_end_velocity,
    input  wire logic signed [31:0] i_end_acceleration,
    input  wire logic [31:0]        i_duration,
    input  wire logic [1:0]         i_axis_tag,
    output logic                    o_valid,
    output logic signed [63:0]      o_coef_power0,
    output logic signed [63:0]      o_coef_power1,
    output logic signed [63:0]      o_coef_power2,
    output logic signed [63:0]      o_coef_power3,
    output logic signed [63:0]      o_coef_power4,
    output logic signed [63:0]      o_coef_power5,
    output logic [1:0]              o_axis_tag_out,
    output logic                    o_saturated
);
    import qbc_pkg::*;

    logic                      r_run;
    logic                      accept;
    logic [FRONT_LAT-1:0]      r_vld;

    // Stage 1: boundary combinations.
    logic signed [33:0]        n_h;
    logic signed [HT_W-1:0]    n_s1_h [0:2];
    logic signed [VT_W-1:0]    n_s1_v [0:2];
    logic signed [AT_W-1:0]    n_s1_a [0:2];
    logic signed [HT_W-1:0]    r_s1_h [0:2];
    logic signed [VT_W-1:0]    r_s1_v [0:2];
    logic signed [AT_W-1:0]    r_s1_a [0:2];
    logic [31:0]               r_s1_t;

    // Stage 2: T^2 and velocity terms.
    logic signed [HT_W-1:0]    r_s2_h [0:2];
    logic signed [PV_W-1:0]    r_s2_pv [0:2];
    logic signed [AT_W-1:0]    r_s2_a [0:2];
    logic [63:0]               r_s2_t2;
    logic [31:0]               r_s2_t;

    // Stage 3: halves of the acceleration terms and of T^3.
    logic signed [HT_W-1:0]    r_s3_h [0:2];
    logic signed [PV_W-1:0]    r_s3_pv [0:2];
    logic signed [PA_W-1:0]    r_s3_pal [0:2];
    logic signed [PA_W-1:0]    r_s3_pah [0:2];
    logic [63:0]               r_s3_t3l;
    logic [63:0]               r_s3_t3h;
    logic [31:0]               r_s3_t;

    // Stage 4: joined acceleration terms and T^3.
    logic signed [HT_W-1:0]    r_s4_h [0:2];
    logic signed [PV_W-1:0]    r_s4_pv [0:2];
    logic signed [NUM_W-1:0]   r_s4_at [0:2];
    logic [T3_W-1:0]           r_s4_t3;
    logic [31:0]               r_s4_t;

    // Stages 5 to 8: numerators wait while T^4 and T^5 are built.
    logic signed [NUM_W-1:0]   r_s5_n [0:2];
    logic signed [NUM_W-1:0]   r_s6_n [0:2];
    logic signed [NUM_W-1:0]   r_s7_n [0:2];
    logic signed [NUM_W-1:0]   r_s8_n [0:2];
    logic [63:0]               r_s5_t4p [0:2];
    logic [63:0]               r_s7_t5p [0:3];
    logic [T3_W-1:0]           r_s5_t3;
    logic [T3_W-1:0]           r_s6_t3;
    logic [T3_W-1:0]           r_s7_t3;
    logic [T3_W-1:0]           r_s8_t3;
    logic [T4_W-1:0]           r_s6_t4;
    logic [T4_W-1:0]           r_s7_t4;
    logic [T4_W-1:0]           r_s8_t4;
    logic [T5_W-1:0]           r_s8_t5;
    logic [31:0]               r_s5_t;
    logic [31:0]               r_s6_t;

    t_side                     n_side;
    t_side                     r_sb  [0:SB_LAT-1];
    logic [SB_LAT-1:0]         r_sbv;
    t_side                     sb_out;

    logic                      v3, v4, v5;
    logic [63:0]               q3, q4, q5;
    logic                      s3, s4, s5;

    assign busy   = ~r_run;
    assign accept = start & ~busy;

    always_comb begin
        n_h       = 34'(i_end_position) - 34'(i_start_position);
        n_s1_h[0] = HT_W'(n_h) * 40'sd20;
        n_s1_h[1] = -(HT_W'(n_h) * 40'sd30);
        n_s1_h[2] = HT_W'(n_h) * 40'sd12;
        n_s1_v[0] = VT_W'(i_end_velocity) * 37'sd8 + VT_W'(i_start_velocity) * 37'sd12;
        n_s1_v[1] = VT_W'(i_end_velocity) * 37'sd14 + VT_W'(i_start_velocity) * 37'sd16;
        n_s1_v[2] = (VT_W'(i_end_velocity) + VT_W'(i_start_velocity)) * 37'sd6;
        n_s1_a[0] = AT_W'(i_start_acceleration) * 35'sd3 - AT_W'(i_end_acceleration);
        n_s1_a[1] = AT_W'(i_start_acceleration) * 35'sd3
                  - AT_W'(i_end_acceleration) * 35'sd2;
        n_s1_a[2] = AT_W'(i_end_acceleration) - AT_W'(i_start_acceleration);
    end

    always_comb begin
        n_side.p0   = i_start_position;
        n_side.v0   = i_start_velocity;
        n_side.a0   = i_start_acceleration;
        n_side.tag  = i_axis_tag;
        n_side.zero = (i_duration == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_vld <= '0;
            r_sbv <= '0;
        end else begin
            r_run <= 1'b1;
            r_vld <= {r_vld[FRONT_LAT-2:0], accept};
            r_sbv <= {r_sbv[SB_LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= n_side;
        for (int i = 1; i < SB_LAT; i++) begin
            r_sb[i] <= r_sb[i-1];
        end

        for (int k = 0; k < 3; k++) begin
            r_s1_h[k]   <= n_s1_h[k];
            r_s1_v[k]   <= n_s1_v[k];
            r_s1_a[k]   <= n_s1_a[k];

            r_s2_h[k]   <= r_s1_h[k];
            r_s2_pv[k]  <= PV_W'(r_s1_v[k]) * PV_W'($signed({1'b0, r_s1_t}));
            r_s2_a[k]   <= r_s1_a[k];

            r_s3_h[k]   <= r_s2_h[k];
            r_s3_pv[k]  <= r_s2_pv[k];
            r_s3_pal[k] <= PA_W'(r_s2_a[k]) * PA_W'($signed({1'b0, r_s2_t2[31:0]}));
            r_s3_pah[k] <= PA_W'(r_s2_a[k]) * PA_W'($signed({1'b0, r_s2_t2[63:32]}));

            r_s4_h[k]   <= r_s3_h[k];
            r_s4_pv[k]  <= r_s3_pv[k];
            r_s4_at[k]  <= (NUM_W'(r_s3_pah[k]) <<< 32) + NUM_W'(r_s3_pal[k]);

            r_s6_n[k]   <= r_s5_n[k];
            r_s7_n[k]   <= r_s6_n[k];
            r_s8_n[k]   <= r_s7_n[k];
        end

        // Signs follow the closed form of each coefficient.
        r_s5_n[0] <= (NUM_W'(r_s4_h[0]) <<< 32) - (NUM_W'(r_s4_pv[0]) <<< 16) - r_s4_at[0];
        r_s5_n[1] <= (NUM_W'(r_s4_h[1]) <<< 32) + (NUM_W'(r_s4_pv[1]) <<< 16) + r_s4_at[1];
        r_s5_n[2] <= (NUM_W'(r_s4_h[2]) <<< 32) - (NUM_W'(r_s4_pv[2]) <<< 16) + r_s4_at[2];

        r_s1_t   <= i_duration;
        r_s2_t   <= r_s1_t;
        r_s3_t   <= r_s2_t;
        r_s4_t   <= r_s3_t;
        r_s5_t   <= r_s4_t;
        r_s6_t   <= r_s5_t;

        r_s2_t2  <= r_s1_t * r_s1_t;
        r_s3_t3l <= r_s2_t2[31:0] * r_s2_t;
        r_s3_t3h <= r_s2_t2[63:32] * r_s2_t;
        r_s4_t3  <= (T3_W'(r_s3_t3h) << 32) + T3_W'(r_s3_t3l);
        r_s5_t3  <= r_s4_t3;
        r_s6_t3  <= r_s5_t3;
        r_s7_t3  <= r_s6_t3;
        r_s8_t3  <= r_s7_t3;

        for (int j = 0; j < 3; j++) begin
            r_s5_t4p[j] <= r_s4_t3[32*j +: 32] * r_s4_t;
        end
        r_s6_t4  <= T4_W'(r_s5_t4p[0]) + (T4_W'(r_s5_t4p[1]) << 32)
                  + (T4_W'(r_s5_t4p[2]) << 64);
        r_s7_t4  <= r_s6_t4;
        r_s8_t4  <= r_s7_t4;

        for (int j = 0; j < 4; j++) begin
            r_s7_t5p[j] <= r_s6_t4[32*j +: 32] * r_s6_t;
        end
        r_s8_t5  <= T5_W'(r_s7_t5p[0]) + (T5_W'(r_s7_t5p[1]) << 32)
                  + (T5_W'(r_s7_t5p[2]) << 64) + (T5_W'(r_s7_t5p[3]) << 96);
    end

    qbc_div #(.DEN_W(T3_W + 1), .SHIFT(32)) u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[FRONT_LAT-1]),
        .i_num   (r_s8_n[0]),
        .i_den   ({r_s8_t3, 1'b0}),
        .o_valid (v3),
        .o_coef  (q3),
        .o_sat   (s3)
    );

    qbc_div #(.DEN_W(T4_W + 1), .SHIFT(48)) u_div4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[FRONT_LAT-1]),
        .i_num   (r_s8_n[1]),
        .i_den   ({r_s8_t4, 1'b0}),
        .o_valid (v4),
        .o_coef  (q4),
        .o_sat   (s4)
    );

    qbc_div #(.DEN_W(T5_W + 1), .SHIFT(64)) u_div5 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[FRONT_LAT-1]),
        .i_num   (r_s8_n[2]),
        .i_den   ({r_s8_t5, 1'b0}),
        .o_valid (v5),
        .o_coef  (q5),
        .o_sat   (s5)
    );

    assign sb_out = r_sb[SB_LAT-1];

    assign o_valid        = v3;
    assign o_coef_power0  = {{16{sb_out.p0[31]}}, sb_out.p0, 16'd0};
    assign o_coef_power1  = {{16{sb_out.v0[31]}}, sb_out.v0, 16'd0};
    assign o_coef_power2  = {{17{sb_out.a0[31]}}, sb_out.a0, 15'd0};
    assign o_coef_power3  = sb_out.zero ? 64'sd0 : $signed(q3);
    assign o_coef_power4  = sb_out.zero ? 64'sd0 : $signed(q4);
    assign o_coef_power5  = sb_out.zero ? 64'sd0 : $signed(q5);
    assign o_axis_tag_out = sb_out.tag;
    assign o_saturated    = sb_out.zero | s3 | s4 | s5;

    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v3 == v4 && v4 == v5 && v3 == r_sbv[SB_LAT-1])
        else $error("divider results out of step with the sideband");

    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && sb_out.zero |-> o_saturated && o_coef_power5 == 64'sd0)
        else $error("zero duration result not flagged");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && busy)
        else $error("activity right after reset");

endmodule
`default_nettype wire

[sim/qbc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbc_checker: coefficient predictor and scoreboard
// Watches accepted beats, works out the six quintic coefficients with wide
// exact arithmetic and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
module qbc_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic signed [31:0] i_start_position,
    input  wire logic signed [31:0] i_start_velocity,
    input  wire logic signed [31:0] i_start_acceleration,
    input  wire logic signed [31:0] i_end_position,
    input  wire logic signed [31:0] i_end_velocity,
    input  wire logic signed [31:0] i_end_acceleration,
    input  wire logic [31:0]        i_duration,
    input  wire logic [1:0]         i_axis_tag,
    input  wire logic               o_valid,
    input  wire logic signed [63:0] o_coef_power0,
    input  wire logic signed [63:0] o_coef_power1,
    input  wire logic signed [63:0] o_coef_power2,
    input  wire logic signed [63:0] o_coef_power3,
    input  wire logic signed [63:0] o_coef_power4,
    input  wire logic signed [63:0] o_coef_power5,
    input  wire logic [1:0]         o_axis_tag_out,
    input  wire logic               o_saturated,
    output int                      o_pending,
    output int                      o_fail_count
);

    typedef struct {
        logic [63:0] coef[6];
        logic [1:0]  tag;
        logic        sat;
    } t_coefs;

    t_coefs coef_queue[$];

    // Magnitude divide with round half away from zero, then clamp to int64.
    function automatic logic [63:0] round_div(logic signed [255:0] num,
                                              logic [255:0] den, int sh,
                                              inout logic sat);
        logic        neg;
        logic [255:0] mag;
        logic [255:0] q;
        logic [255:0] r;
        neg = num[255];
        mag = neg ? -num : num;
        mag = mag << sh;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den) q = q + 1;
        if (!neg) begin
            if (q > 256'h7FFF_FFFF_FFFF_FFFF) begin
                sat = 1'b1;
                return 64'h7FFF_FFFF_FFFF_FFFF;
            end
            return q[63:0];
        end
        if (q > 256'h8000_0000_0000_0000) begin
            sat = 1'b1;
            return 64'h8000_0000_0000_0000;
        end
        return -q[63:0];
    endfunction

    function automatic t_coefs predict_coefs(logic signed [31:0] p0, v0, a0, p1, v1, a1,
                                             logic [31:0] dur, logic [1:0] tag);
        t_coefs c;
        logic signed [255:0] h;
        logic signed [255:0] t;
        logic signed [255:0] t2;
        logic signed [255:0] n;
        logic signed [255:0] sv0;
        logic signed [255:0] sv1;
        logic signed [255:0] sa0;
        logic signed [255:0] sa1;
        logic sat;
        sat = 1'b0;
        sv0 = 256'(v0);
        sv1 = 256'(v1);
        sa0 = 256'(a0);
        sa1 = 256'(a1);
        h = 256'(p1) - 256'(p0);
        t = {224'b0, dur};
        t2 = t * t;
        c.coef[0] = 64'(256'(p0) <<< 16);
        c.coef[1] = 64'(sv0 <<< 16);
        c.coef[2] = 64'(sa0 <<< 15);
        if (dur == 32'd0) begin
            c.coef[3] = '0;
            c.coef[4] = '0;
            c.coef[5] = '0;
            sat = 1'b1;
        end else begin
            n = ((20 * h) <<< 32) - (((8 * sv1 + 12 * sv0) * t) <<< 16)
                - (3 * sa0 - sa1) * t2;
            c.coef[3] = round_div(n, 2 * t2 * t, 32, sat);
            n = ((-30 * h) <<< 32) + (((14 * sv1 + 16 * sv0) * t) <<< 16)
                + (3 * sa0 - 2 * sa1) * t2;
            c.coef[4] = round_div(n, 2 * t2 * t2, 48, sat);
            n = ((12 * h) <<< 32) - (((6 * (sv1 + sv0)) * t) <<< 16)
                + (sa1 - sa0) * t2;
            c.coef[5] = round_div(n, 2 * t2 * t2 * t, 64, sat);
        end
        c.tag = tag;
        c.sat = sat;
        return c;
    endfunction

    initial begin
        o_fail_count = 0;
    end

    assign o_pending = coef_queue.size();

    always @(posedge i_clk) begin
        t_coefs exp_c;
        logic [63:0] got[6];
        if (i_rst_n && start && !busy) begin
            coef_queue.push_back(predict_coefs(i_start_position, i_start_velocity,
                i_start_acceleration, i_end_position, i_end_velocity,
                i_end_acceleration, i_duration, i_axis_tag));
        end
        if (i_rst_n && o_valid) begin
            if (coef_queue.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                o_fail_count = o_fail_count + 1;
            end else begin
                exp_c = coef_queue.pop_front();
                got[0] = o_coef_power0;
                got[1] = o_coef_power1;
                got[2] = o_coef_power2;
                got[3] = o_coef_power3;
                got[4] = o_coef_power4;
                got[5] = o_coef_power5;
                for (int k = 0; k < 6; k++) begin
                    if (got[k] !== exp_c.coef[k]) begin
                        $display("%0t: coef_power%0d expected %h actual %h",
                                 $time, k, exp_c.coef[k], got[k]);
                        o_fail_count = o_fail_count + 1;
                    end
                end
                if (o_axis_tag_out !== exp_c.tag) begin
                    $display("%0t: axis_tag_out expected %0d actual %0d",
                             $time, exp_c.tag, o_axis_tag_out);
                    o_fail_count = o_fail_count + 1;
                end
                if (o_saturated !== exp_c.sat) begin
                    $display("%0t: saturated expected %0d actual %0d",
                             $time, exp_c.sat, o_saturated);
                    o_fail_count = o_fail_count + 1;
                end
            end
        end
    end

endmodule

[sim/tb_quintic_boundary_coefficients.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quintic_boundary_coefficients: testbench top
// Drives directed corner beats and random boundary conditions with random
// gaps into the block; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_quintic_boundary_coefficients;

    localparam int N_RANDOM   = 1900;
    localparam int IDLE_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [31:0] p0, v0, a0, p1, v1, a1;
    logic [31:0] dur;
    logic [1:0]  tag;
    logic o_valid;
    logic signed [63:0] c0, c1, c2, c3, c4, c5;
    logic [1:0] tag_out;
    logic sat_out;
    int pending;
    int fail_count;
    int idle_cycles;

    quintic_boundary_coefficients u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_start_position(p0), .i_start_velocity(v0), .i_start_acceleration(a0),
        .i_end_position(p1), .i_end_velocity(v1), .i_end_acceleration(a1),
        .i_duration(dur), .i_axis_tag(tag), .o_valid(o_valid),
        .o_coef_power0(c0), .o_coef_power1(c1), .o_coef_power2(c2),
        .o_coef_power3(c3), .o_coef_power4(c4), .o_coef_power5(c5),
        .o_axis_tag_out(tag_out), .o_saturated(sat_out)
    );

    qbc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_start_position(p0), .i_start_velocity(v0), .i_start_acceleration(a0),
        .i_end_position(p1), .i_end_velocity(v1), .i_end_acceleration(a1),
        .i_duration(dur), .i_axis_tag(tag), .o_valid(o_valid),
        .o_coef_power0(c0), .o_coef_power1(c1), .o_coef_power2(c2),
        .o_coef_power3(c3), .o_coef_power4(c4), .o_coef_power5(c5),
        .o_axis_tag_out(tag_out), .o_saturated(sat_out),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Any accepted beat on either side restarts the idle count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("quintic_boundary_coefficients verification failed");
            $finish;
        end
    end

    task automatic send_beat(logic [31:0] sp, sv, sa, ep, ev, ea, t, logic [1:0] tg);
        int gap;
        logic was_busy;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        p0 <= sp; v0 <= sv; a0 <= sa;
        p1 <= ep; v1 <= ev; a1 <= ea;
        dur <= t; tag <= tg;
        forever begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
            if (!was_busy) break;
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 65535) << 8) - 32'sd8388608);
            2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            default: return $urandom() >>> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [31:0] rand_duration();
        logic [31:0] t;
        t = $urandom() >> $urandom_range(0, 31);
        return (t == 32'd0) ? 32'd1 : t;
    endfunction

    initial begin
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        p0 = '0; v0 = '0; a0 = '0; p1 = '0; v1 = '0; a1 = '0;
        dur = 32'h0001_0000;
        tag = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: extremes of every field, zero duration, tag 3.
        send_beat(0, 0, 0, 0, 0, 0, 32'h0001_0000, 2'd0);
        send_beat(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 2'd1);
        send_beat(mx, mx, mx, mn, mn, mn, 32'd1, 2'd2);
        send_beat(mn, mn, mn, mx, mx, mx, 32'd1, 2'd3);
        send_beat(mx, mx, mx, mn, mn, mn, 32'hFFFF_FFFF, 2'd0);
        send_beat(mn, mn, mn, mx, mx, mx, 32'hFFFF_FFFF, 2'd1);
        send_beat(mx, mx, mx, mx, mx, mx, 32'h0001_0000, 2'd2);
        send_beat(mn, mn, mn, mn, mn, mn, 32'h0001_0000, 2'd3);
        send_beat(32'h1234_5678, 32'hFFFF_0000, 32'h0000_8000, 32'h9ABC_DEF0,
                  32'h0003_0000, 32'hFFFE_0000, 32'd0, 2'd1);
        send_beat(mx, mn, mx, mn, mx, mn, 32'd0, 2'd3);
        send_beat(0, 0, 0, 32'd1, 0, 0, 32'hFFFF_FFFF, 2'd0);
        send_beat(0, 32'd1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'd1, 32'h0000_0100, 2'd2);
        send_beat(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 32'h8000_0000, 2'd1);
        send_beat(0, mx, 0, 0, mn, 0, 32'd2, 2'd0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                // Let the pipeline drain completely before carrying on.
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            send_beat(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), rand_duration(), 2'($urandom_range(0, 3)));
        end
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("quintic_boundary_coefficients verification clean");
        end else begin
            $display("quintic_boundary_coefficients verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/qbc_pkg.sv
src/qbc_div.sv
src/quintic_boundary_coefficients.sv
sim/qbc_checker.sv
sim/tb_quintic_boundary_coefficients.sv
